// ----- rtl/core/pst_pkg.sv -----
// ----------------------------------------------------------------------------
// pst_pkg
// Shared constants, types and helpers of the port scan tracker.
// ----------------------------------------------------------------------------
package pst_pkg;

  // Table geometry
  localparam int TRACKERS          = 16;
  localparam int PORTS_PER_TRACKER = 32;

  // Field widths
  localparam int ADDR_W  = 32;
  localparam int PORT_W  = 16;
  localparam int LIMIT_W = 6;
  localparam int OUT_CNT_W = 6;

  // Derived widths
  localparam int TRK_W  = (TRACKERS > 1) ? $clog2(TRACKERS) : 1;
  localparam int CNT_W  = $clog2(PORTS_PER_TRACKER + 1);
  localparam int RAM_DEPTH = TRACKERS * PORTS_PER_TRACKER;
  localparam int RAM_AW = (RAM_DEPTH > 1) ? $clog2(RAM_DEPTH) : 1;
  localparam int RAM_W  = PORT_W + 1;

  localparam logic [LIMIT_W-1:0] SCAN_LIMIT_RESET = LIMIT_W'(10);

  // Well-known service ports
  localparam int WELLKNOWN_N = 10;
  localparam logic [PORT_W-1:0] WELLKNOWN_PORTS [WELLKNOWN_N] = '{
    16'd80, 16'd443, 16'd53, 16'd25, 16'd587,
    16'd110, 16'd995, 16'd143, 16'd993, 16'd21
  };

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MATCH,
    ST_SCAN,
    ST_APPEND,
    ST_REPORT
  } state_t;

  function automatic logic is_wellknown(input logic [PORT_W-1:0] port);
    logic hit;
    hit = 1'b0;
    for (int k = 0; k < WELLKNOWN_N; k++) begin
      if (port == WELLKNOWN_PORTS[k]) begin
        hit = 1'b1;
      end
    end
    return hit;
  endfunction

  // Clamp an entry count to the reported width
  function automatic logic [OUT_CNT_W-1:0] sat_count(input logic [CNT_W-1:0] v);
    int unsigned x;
    x = 32'(v);
    return (x > 32'd63) ? OUT_CNT_W'(63) : OUT_CNT_W'(x);
  endfunction

endpackage

// ----- rtl/core/pst_in_if.sv -----
// ----------------------------------------------------------------------------
// pst_in_if
// Connection attempt channel: valid/ready handshake with the attempt fields.
// ----------------------------------------------------------------------------
interface pst_in_if;
  import pst_pkg::*;

  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] source_address;
  logic [PORT_W-1:0] dest_port;
  logic              succeeded;

  modport source (output valid, source_address, dest_port, succeeded, input ready);
  modport sink   (input valid, source_address, dest_port, succeeded, output ready);
endinterface

// ----- rtl/core/pst_out_if.sv -----
// ----------------------------------------------------------------------------
// pst_out_if
// Tracker result channel: valid/ready handshake with counts and flags.
// ----------------------------------------------------------------------------
interface pst_out_if;
  import pst_pkg::*;

  logic                 valid;
  logic                 ready;
  logic                 tracked;
  logic [OUT_CNT_W-1:0] unique_count;
  logic [OUT_CNT_W-1:0] wellknown_count;
  logic                 scan_flag;
  logic                 browsing_flag;

  modport source (output valid, tracked, unique_count, wellknown_count, scan_flag,
                  browsing_flag, input ready);
  modport sink   (input valid, tracked, unique_count, wellknown_count, scan_flag,
                  browsing_flag, output ready);
endinterface

// ----- rtl/core/port_scan_tracker.sv -----
// ----------------------------------------------------------------------------
// port_scan_tracker
// Per-source port scan tracker with an iterative lookup sequencer.
// ----------------------------------------------------------------------------
// One connection attempt word is handled at a time. After the accept cycle a
// single address comparator walks the tracker entries, one per cycle, until
// the source matches or the table ends; a new source claims the lowest free
// entry. The entry's stored ports are then read from the port RAM one per
// cycle through its registered read port and compared with the new port,
// stopping early on a duplicate; without one, the append step writes the
// port if the entry has room. The report step loads the result register. An
// untracked source (table full) goes straight from the walk to the report
// step. The result register lets the next word be accepted while a result
// waits to be taken.
// ----------------------------------------------------------------------------
module port_scan_tracker (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_wr_en,
  input  logic [pst_pkg::LIMIT_W-1:0] cfg_wr_data,
  pst_in_if.sink                 req,
  pst_out_if.source              rsp
);
  import pst_pkg::*;

  state_t state, state_next;

  // Configuration
  logic [LIMIT_W-1:0] scan_limit;

  // Tracker entries
  logic              entry_valid    [TRACKERS];
  logic [ADDR_W-1:0] entry_address  [TRACKERS];
  logic [CNT_W-1:0]  entry_port_count      [TRACKERS];
  logic [CNT_W-1:0]  entry_wellknown_count [TRACKERS];

  // Captured word and sequencer registers
  logic [ADDR_W-1:0] item_address;
  logic [PORT_W-1:0] item_port;
  logic              item_ok;
  logic [TRK_W-1:0]  trk_idx;
  logic [TRK_W-1:0]  hit_idx;
  logic [TRK_W-1:0]  spare_idx;
  logic              spare_found;
  logic              untracked;
  logic [CNT_W-1:0]  port_idx;
  logic              cmp_pending;

  // Result register
  logic                 out_valid;
  logic                 out_tracked;
  logic [OUT_CNT_W-1:0] out_unique;
  logic [OUT_CNT_W-1:0] out_wellknown;
  logic                 out_scan;
  logic                 out_browsing;

  // Control from the sequencer
  logic accept;
  logic step_next;
  logic take_hit;
  logic claim;
  logic mark_full;
  logic issue;
  logic append;
  logic load_result;
  logic [TRK_W-1:0] claim_idx;

  // Datapath signals
  logic              is_hit;
  logic              is_free;
  logic              last_trk;
  logic              dup_now;
  logic [CNT_W-1:0]  cur_count;
  logic [CNT_W-1:0]  cur_wellknown;
  logic [RAM_AW-1:0] ram_raddr;
  logic [RAM_AW-1:0] ram_waddr;
  logic [RAM_W-1:0]  ram_wdata;
  logic [RAM_W-1:0]  ram_rdata;

  // Compare the current entry and the returned port
  assign is_hit   = entry_valid[trk_idx] && (entry_address[trk_idx] == item_address);
  assign is_free  = !entry_valid[trk_idx];
  assign last_trk = (trk_idx == TRK_W'(TRACKERS - 1));
  assign claim_idx = spare_found ? spare_idx : trk_idx;
  assign cur_count     = entry_port_count[hit_idx];
  assign cur_wellknown = entry_wellknown_count[hit_idx];
  assign dup_now  = cmp_pending && (ram_rdata[RAM_W-1:1] == item_port);

  assign ram_raddr = RAM_AW'(int'(hit_idx) * PORTS_PER_TRACKER + int'(port_idx));
  assign ram_waddr = RAM_AW'(int'(hit_idx) * PORTS_PER_TRACKER + int'(cur_count));
  assign ram_wdata = {item_port, item_ok};

  pst_ram #(
    .WIDTH (RAM_W),
    .DEPTH (RAM_DEPTH)
  ) u_port_ram (
    .clk   (clk),
    .we    (append),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Hold the sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sequence the lookup, duplicate scan, append and report
  always_comb begin
    state_next  = state;
    accept      = 1'b0;
    step_next   = 1'b0;
    take_hit    = 1'b0;
    claim       = 1'b0;
    mark_full   = 1'b0;
    issue       = 1'b0;
    append      = 1'b0;
    load_result = 1'b0;
    unique case (state)
      ST_IDLE: begin
        accept = req.valid;
        if (req.valid) begin
          state_next = ST_MATCH;
        end
      end
      ST_MATCH: begin
        priority if (is_hit) begin
          take_hit   = 1'b1;
          state_next = ST_SCAN;
        end else if (!last_trk) begin
          step_next = 1'b1;
        end else if (spare_found || is_free) begin
          claim      = 1'b1;
          state_next = ST_SCAN;
        end else begin
          mark_full  = 1'b1;
          state_next = ST_REPORT;
        end
      end
      ST_SCAN: begin
        issue = (port_idx < cur_count) && !dup_now;
        priority if (dup_now) begin
          state_next = ST_REPORT;
        end else if (!issue && !cmp_pending) begin
          state_next = ST_APPEND;
        end else begin
          state_next = ST_SCAN;
        end
      end
      ST_APPEND: begin
        append     = (cur_count < CNT_W'(PORTS_PER_TRACKER));
        state_next = ST_REPORT;
      end
      ST_REPORT: begin
        if (!out_valid || rsp.ready) begin
          load_result = 1'b1;
          state_next  = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign req.ready = (state == ST_IDLE);

  // Capture the word and advance the walk and scan counters
  always_ff @(posedge clk) begin
    if (accept) begin
      item_address <= req.source_address;
      item_port    <= req.dest_port;
      item_ok      <= req.succeeded;
      trk_idx      <= '0;
    end else if (step_next) begin
      trk_idx <= trk_idx + TRK_W'(1);
    end
    if (step_next && is_free && !spare_found) begin
      spare_idx <= trk_idx;
    end
    if (take_hit) begin
      hit_idx <= trk_idx;
    end else if (claim) begin
      hit_idx <= claim_idx;
    end
    if (take_hit || claim) begin
      port_idx <= '0;
    end else if (issue) begin
      port_idx <= port_idx + CNT_W'(1);
    end
  end

  // Control flags of the walk
  always_ff @(posedge clk) begin
    if (rst) begin
      spare_found <= 1'b0;
      untracked   <= 1'b0;
      cmp_pending <= 1'b0;
    end else begin
      if (accept) begin
        spare_found <= 1'b0;
        untracked   <= 1'b0;
      end else begin
        if (step_next && is_free) begin
          spare_found <= 1'b1;
        end
        if (mark_full) begin
          untracked <= 1'b1;
        end
      end
      cmp_pending <= issue;
    end
  end

  // Claim entries and bump counts
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int t = 0; t < TRACKERS; t++) begin
        entry_valid[t]           <= 1'b0;
        entry_port_count[t]      <= '0;
        entry_wellknown_count[t] <= '0;
      end
    end else if (claim) begin
      entry_valid[claim_idx]           <= 1'b1;
      entry_address[claim_idx]         <= item_address;
      entry_port_count[claim_idx]      <= '0;
      entry_wellknown_count[claim_idx] <= '0;
    end else if (append) begin
      entry_port_count[hit_idx] <= cur_count + CNT_W'(1);
      if (is_wellknown(item_port)) begin
        entry_wellknown_count[hit_idx] <= cur_wellknown + CNT_W'(1);
      end
    end
  end

  // Scan limit register
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_limit <= SCAN_LIMIT_RESET;
    end else if (cfg_wr_en) begin
      scan_limit <= cfg_wr_data;
    end
  end

  // Load and drop the result word
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_result) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_result) begin
      if (untracked) begin
        out_tracked   <= 1'b0;
        out_unique    <= '0;
        out_wellknown <= '0;
        out_scan      <= 1'b0;
        out_browsing  <= 1'b0;
      end else begin
        out_tracked   <= 1'b1;
        out_unique    <= sat_count(cur_count);
        out_wellknown <= sat_count(cur_wellknown);
        out_scan      <= (32'(cur_count) >= 32'(scan_limit));
        out_browsing  <= (32'(cur_wellknown) > 32'(cur_count >> 1));
      end
    end
  end

  assign rsp.valid           = out_valid;
  assign rsp.tracked         = out_tracked;
  assign rsp.unique_count    = out_unique;
  assign rsp.wellknown_count = out_wellknown;
  assign rsp.scan_flag       = out_scan;
  assign rsp.browsing_flag   = out_browsing;

  // Entry counts stay within the entry size during the scan
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> (32'(cur_count) <= 32'(PORTS_PER_TRACKER)))
    else $error("entry port count beyond entry size");

  // Well-known count never exceeds the unique count at report time
  a_wk_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_REPORT && !untracked) |-> (cur_wellknown <= cur_count))
    else $error("well-known count exceeds unique count");

  // A new result only comes from the report step
  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == ST_REPORT))
    else $error("result loaded outside report step");

  // Compared read data always belongs to a read issued in the scan
  a_cmp_src: assert property (@(posedge clk) disable iff (rst)
    cmp_pending |-> ($past(state) == ST_SCAN && state == ST_SCAN))
    else $error("port compare outside the scan");

endmodule

// ----- rtl/core/pst_ram.sv -----
// ----------------------------------------------------------------------------
// pst_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
